// ===== rtl/core/bssp_pkg.sv =====
package bssp_pkg;

	localparam int FRAC_BITS      = 8;
	localparam int MAX_STAMPS_DEF = 64;

	localparam int COORD_W = 13;
	localparam int DELTA_W = COORD_W + 1;
	localparam int LEFT_W  = 16;
	localparam int SIZE_W  = 9;
	localparam int CANV_W  = 13;
	localparam int OUT_W   = 14;

	// squared length of a segment, radicand, root, total distance
	localparam int SQ_W   = 28;
	localparam int RAD_W  = SQ_W + 2 * FRAC_BITS;
	localparam int DIST_W = RAD_W / 2;
	localparam int TOT_W  = DIST_W + 1;

	// direction divide: |d| * ONE * ONE / dist, quotient never above ONE
	localparam int NUM_W  = COORD_W + 2 * FRAC_BITS;
	localparam int QUO_W  = FRAC_BITS + 1;
	localparam int STEP_W = FRAC_BITS + 2;

	// shared multiplier operands
	localparam int MA_W   = TOT_W + 1;
	localparam int MB_W   = DELTA_W;
	localparam int PROD_W = MA_W + MB_W;
	localparam int DRAW_W = 18;

	localparam int SPC_W    = 14;
	localparam int RECIP_SH = 24;
	localparam logic [20:0] RECIP_10 = 21'd1677722;

	localparam logic [1:0] REG_CANVAS_W = 2'd0;
	localparam logic [1:0] REG_CANVAS_H = 2'd1;
	localparam logic [1:0] REG_BRUSH_W  = 2'd2;
	localparam logic [1:0] REG_BRUSH_H  = 2'd3;

	// stamp position on one axis: start*ONE + (step*t)/ONE - size*ONE/2, then /ONE,
	// both divides truncating toward zero
	function automatic logic signed [DRAW_W-1:0] stamp_origin(
		input logic signed [PROD_W-1:0]  prod,
		input logic signed [COORD_W-1:0] start,
		input logic [SIZE_W-1:0]         size
	);
		logic signed [PROD_W-1:0] off;
		logic signed [PROD_W-1:0] pos;
		logic signed [PROD_W-1:0] rnd;
		off = prod + (prod[PROD_W-1] ? PROD_W'((1 << FRAC_BITS) - 1) : '0);
		off = off >>> FRAC_BITS;
		pos = (PROD_W'(start) <<< FRAC_BITS) + off
			- ($signed({{(PROD_W-SIZE_W){1'b0}}, size}) <<< (FRAC_BITS - 1));
		rnd = pos + (pos[PROD_W-1] ? PROD_W'((1 << FRAC_BITS) - 1) : '0);
		rnd = rnd >>> FRAC_BITS;
		return rnd[DRAW_W-1:0];
	endfunction

endpackage

// ===== rtl/core/bssp_if.sv =====
interface bssp_seg_if;
	import bssp_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] seg_start_x;
	logic signed [COORD_W-1:0] seg_start_y;
	logic signed [COORD_W-1:0] seg_end_x;
	logic signed [COORD_W-1:0] seg_end_y;
	logic [LEFT_W-1:0]         leftover_in;

	modport source (output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
		leftover_in, input ready);
	modport sink (input valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
		leftover_in, output ready);
endinterface

interface bssp_stamp_if;
	import bssp_pkg::*;
	logic                      valid;
	logic                      ready;
	logic                      stamp_valid;
	logic signed [OUT_W-1:0]   draw_x;
	logic signed [OUT_W-1:0]   draw_y;
	logic [OUT_W-2:0]          brush_first_col;
	logic [OUT_W-2:0]          brush_first_row;
	logic signed [OUT_W-1:0]   brush_end_col;
	logic signed [OUT_W-1:0]   brush_end_row;
	logic [LEFT_W-1:0]         leftover_out;
	logic                      truncated;
	logic                      last;

	modport source (output valid, stamp_valid, draw_x, draw_y, brush_first_col,
		brush_first_row, brush_end_col, brush_end_row, leftover_out, truncated, last,
		input ready);
	modport sink (input valid, stamp_valid, draw_x, draw_y, brush_first_col,
		brush_first_row, brush_end_col, brush_end_row, leftover_out, truncated, last,
		output ready);
endinterface

// ===== rtl/core/brush_stroke_stamp_placer_unit.sv =====
// Brush stamp placer: places brush stamps along one stroke segment.
// Input channel seg carries one segment (start, end, leftover distance in Q.8).
// Output channel stamp carries one transfer per stamp: the clipped canvas origin
// of the brush window, the first and end brush column/row, and on the transfer
// flagged last the leftover distance and the truncated flag. A segment with no
// stamp gives one transfer with stamp_valid low and last high.
// APB port: canvas_width, canvas_height, brush_width, brush_height at 0x0..0xC,
// which the user must write only while the block is idle (the block does not enforce it);
// pready is always high. An item runs through one shared multiplier and a shared
// one-bit-a-cycle square root and divider: squaring of dx and dy, the root, a setup
// step, the x and y divides (skipped for a zero-length segment), a start step, then
// for each stamp the x and y multiplies, the y position and the emit, which waits
// while the result register is full and the sink stalls; seg.ready is high only
// while the unit is idle. The result register holds a finished transfer while the
// sink stalls; the sequencer loads the next only once it is empty or being taken.
// Reset (arst_n low) restores the register defaults and empties the unit.
module brush_stroke_stamp_placer_unit #(
	parameter int MAX_STAMPS = bssp_pkg::MAX_STAMPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	bssp_seg_if.sink    seg,
	bssp_stamp_if.source stamp
);
	import bssp_pkg::*;

	localparam int KW = $clog2(MAX_STAMPS + 1);
	localparam int CW = $clog2(DIST_W);

	typedef enum logic [3:0] {
		S_IDLE, S_SQX, S_SQY, S_ROOT, S_DINIT, S_DIVX, S_DIVY,
		S_START, S_MULX, S_MULY, S_POSY, S_EMIT, S_EMPTY
	} state_t;

	state_t state_q;

	// configuration
	logic [CANV_W-1:0] canvas_w_q, canvas_h_q;
	logic [SIZE_W-1:0] brush_w_q, brush_h_q;

	// segment
	logic signed [COORD_W-1:0] sx_q, sy_q;
	logic signed [DELTA_W-1:0] dx_q, dy_q;
	logic [LEFT_W-1:0]         left_q;
	logic [SPC_W-1:0]          spacing_q;

	// root / divide
	logic [SQ_W-1:0]   sq_q;
	logic [RAD_W-1:0]  rad_q;
	logic [DIST_W:0]   rem_q;
	logic [DIST_W-1:0] root_q;
	logic [DIST_W-1:0] rdiv_q;
	logic [QUO_W-1:0]  lo_q, quo_q;
	logic [CW-1:0]     cnt_q;
	logic signed [STEP_W-1:0] stepx_q, stepy_q;

	// stamp walk
	logic [TOT_W-1:0]         total_q, acc_q;
	logic [KW-1:0]            k_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [DRAW_W-1:0] drawx_q, drawy_q;

	// result register
	logic                    ovalid_q, ostamp_q, otrunc_q, olast_q;
	logic signed [OUT_W-1:0] odx_q, ody_q, oecol_q, oerow_q;
	logic [OUT_W-2:0]        ofcol_q, ofrow_q;
	logic [LEFT_W-1:0]       oleft_q;

	// combinational
	logic                     cfg_wr;
	logic [SIZE_W+FRAC_BITS+20:0] spc_full;
	logic [SPC_W-1:0]         spc_new;
	logic signed [MA_W-1:0]   mul_a;
	logic signed [MB_W-1:0]   mul_b;
	logic signed [PROD_W-1:0] prod;
	logic [SQ_W-1:0]          sq_sum;
	logic [DIST_W+2:0]        rt_r2, rt_trial;
	logic [DIST_W:0]          dv_r2;
	logic                     dv_bit;
	logic [QUO_W-1:0]         quo_fin;
	logic signed [STEP_W-1:0] step_fin;
	logic [NUM_W-1:0]         num_x, num_y;
	logic [DELTA_W-1:0]       abs_dx, abs_dy;
	logic signed [MA_W-1:0]   t_val;
	logic [TOT_W-1:0]         acc_nxt, rem_raw;
	logic [LEFT_W-1:0]        rem_sat, tot_sat;
	logic                     more, at_max, out_free;
	logic signed [OUT_W-1:0]  cx_org, cy_org, cx_end, cy_end;
	logic [OUT_W-2:0]         cx_first, cy_first;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_comb begin
		case (paddr[3:2])
			REG_CANVAS_W: prdata = 32'(canvas_w_q);
			REG_CANVAS_H: prdata = 32'(canvas_h_q);
			REG_BRUSH_W:  prdata = 32'(brush_w_q);
			REG_BRUSH_H:  prdata = 32'(brush_h_q);
			default:      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canvas_w_q <= CANV_W'(640);
			canvas_h_q <= CANV_W'(480);
			brush_w_q  <= SIZE_W'(32);
			brush_h_q  <= SIZE_W'(32);
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_CANVAS_W: canvas_w_q <= pwdata[CANV_W-1:0];
				REG_CANVAS_H: canvas_h_q <= pwdata[CANV_W-1:0];
				REG_BRUSH_W:  brush_w_q  <= pwdata[SIZE_W-1:0];
				REG_BRUSH_H:  brush_h_q  <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// spacing = floor(brush_width*ONE/10) by reciprocal, floor of ONE/2
	always_comb begin
		spc_full = $bits(spc_full)'({brush_w_q, {FRAC_BITS{1'b0}}}) * $bits(spc_full)'(RECIP_10);
		spc_new  = spc_full[RECIP_SH +: SPC_W];
		if (spc_new < SPC_W'(1 << (FRAC_BITS - 1)))
			spc_new = SPC_W'(1 << (FRAC_BITS - 1));
	end

	assign abs_dx = dx_q[DELTA_W-1] ? -dx_q : dx_q;
	assign abs_dy = dy_q[DELTA_W-1] ? -dy_q : dy_q;
	assign num_x  = {abs_dx[COORD_W-1:0], {(2*FRAC_BITS){1'b0}}};
	assign num_y  = {abs_dy[COORD_W-1:0], {(2*FRAC_BITS){1'b0}}};
	assign t_val  = $signed({1'b0, acc_q}) - $signed(MA_W'(left_q));

	// the one multiplier: squares first, then step * t for each stamp
	always_comb begin
		case (state_q)
			S_SQX:   begin mul_a = MA_W'(dx_q);  mul_b = dx_q; end
			S_SQY:   begin mul_a = MA_W'(dy_q);  mul_b = dy_q; end
			S_MULX:  begin mul_a = t_val;        mul_b = MB_W'(stepx_q); end
			S_MULY:  begin mul_a = t_val;        mul_b = MB_W'(stepy_q); end
			default: begin mul_a = '0;           mul_b = '0; end
		endcase
		prod = PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	assign sq_sum = sq_q + prod[SQ_W-1:0];

	// square root, two radicand bits per cycle
	assign rt_r2    = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign rt_trial = (DIST_W+3)'({root_q, 2'b01});

	// restoring divide, one quotient bit per cycle
	assign dv_r2    = {rdiv_q, lo_q[QUO_W-1]};
	assign dv_bit   = (dv_r2 >= {1'b0, root_q});
	assign quo_fin  = {quo_q[QUO_W-2:0], dv_bit};
	always_comb begin
		if ((state_q == S_DIVX) ? dx_q[DELTA_W-1] : dy_q[DELTA_W-1])
			step_fin = -$signed(STEP_W'(quo_fin));
		else
			step_fin = $signed(STEP_W'(quo_fin));
	end

	// stamp bookkeeping
	assign acc_nxt = acc_q + TOT_W'(spacing_q);
	assign at_max  = (k_q == KW'(MAX_STAMPS - 1));
	assign more    = (acc_nxt <= total_q);
	assign rem_raw = total_q - acc_q;
	assign rem_sat = (rem_raw > TOT_W'(16'hFFFF)) ? 16'hFFFF : rem_raw[LEFT_W-1:0];
	assign tot_sat = (total_q > TOT_W'(16'hFFFF)) ? 16'hFFFF : total_q[LEFT_W-1:0];
	assign out_free = !ovalid_q || stamp.ready;

	bssp_clip u_clip_x (
		.draw(drawx_q), .size(brush_w_q), .canvas(canvas_w_q),
		.origin(cx_org), .first(cx_first), .bound(cx_end)
	);
	bssp_clip u_clip_y (
		.draw(drawy_q), .size(brush_h_q), .canvas(canvas_h_q),
		.origin(cy_org), .first(cy_first), .bound(cy_end)
	);

	assign seg.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ovalid_q <= 1'b0;
			cnt_q    <= '0;
			k_q      <= '0;
		end else begin
			if (ovalid_q && stamp.ready)
				ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (seg.valid) begin
						sx_q      <= seg.seg_start_x;
						sy_q      <= seg.seg_start_y;
						dx_q      <= DELTA_W'(seg.seg_end_x) - DELTA_W'(seg.seg_start_x);
						dy_q      <= DELTA_W'(seg.seg_end_y) - DELTA_W'(seg.seg_start_y);
						left_q    <= seg.leftover_in;
						spacing_q <= spc_new;
						state_q   <= S_SQX;
					end
				end
				S_SQX: begin
					sq_q    <= prod[SQ_W-1:0];
					state_q <= S_SQY;
				end
				S_SQY: begin
					rad_q   <= {sq_sum, {(2*FRAC_BITS){1'b0}}};
					rem_q   <= '0;
					root_q  <= '0;
					cnt_q   <= CW'(DIST_W - 1);
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (rt_r2 >= rt_trial) begin
						rem_q  <= (DIST_W+1)'(rt_r2 - rt_trial);
						root_q <= {root_q[DIST_W-2:0], 1'b1};
					end else begin
						rem_q  <= rt_r2[DIST_W:0];
						root_q <= {root_q[DIST_W-2:0], 1'b0};
					end
					rad_q <= {rad_q[RAD_W-3:0], 2'b00};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0)
						state_q <= S_DINIT;
				end
				S_DINIT: begin
					total_q <= TOT_W'(left_q) + TOT_W'(root_q);
					stepx_q <= '0;
					stepy_q <= '0;
					rdiv_q  <= DIST_W'(num_x[NUM_W-1:QUO_W]);
					lo_q    <= num_x[QUO_W-1:0];
					quo_q   <= '0;
					cnt_q   <= CW'(QUO_W - 1);
					state_q <= (root_q == '0) ? S_START : S_DIVX;
				end
				S_DIVX, S_DIVY: begin
					rdiv_q <= dv_bit ? DIST_W'(dv_r2 - {1'b0, root_q}) : dv_r2[DIST_W-1:0];
					lo_q   <= {lo_q[QUO_W-2:0], 1'b0};
					quo_q  <= quo_fin;
					cnt_q  <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						if (state_q == S_DIVX) begin
							stepx_q <= step_fin;
							rdiv_q  <= DIST_W'(num_y[NUM_W-1:QUO_W]);
							lo_q    <= num_y[QUO_W-1:0];
							quo_q   <= '0;
							cnt_q   <= CW'(QUO_W - 1);
							state_q <= S_DIVY;
						end else begin
							stepy_q <= step_fin;
							state_q <= S_START;
						end
					end
				end
				S_START: begin
					acc_q   <= TOT_W'(spacing_q);
					k_q     <= '0;
					state_q <= (TOT_W'(spacing_q) > total_q) ? S_EMPTY : S_MULX;
				end
				S_MULX: begin
					prod_q  <= prod;
					state_q <= S_MULY;
				end
				S_MULY: begin
					prod_q  <= prod;
					drawx_q <= stamp_origin(prod_q, sx_q, brush_w_q);
					state_q <= S_POSY;
				end
				S_POSY: begin
					drawy_q <= stamp_origin(prod_q, sy_q, brush_h_q);
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						ovalid_q <= 1'b1;
						ostamp_q <= 1'b1;
						odx_q    <= cx_org;
						ody_q    <= cy_org;
						ofcol_q  <= cx_first;
						ofrow_q  <= cy_first;
						oecol_q  <= cx_end;
						oerow_q  <= cy_end;
						olast_q  <= !more || at_max;
						otrunc_q <= more && at_max;
						oleft_q  <= (!more || at_max) ? rem_sat : '0;
						if (!more || at_max) begin
							state_q <= S_IDLE;
						end else begin
							acc_q   <= acc_nxt;
							k_q     <= k_q + 1'b1;
							state_q <= S_MULX;
						end
					end
				end
				S_EMPTY: begin
					if (out_free) begin
						ovalid_q <= 1'b1;
						ostamp_q <= 1'b0;
						odx_q    <= '0;
						ody_q    <= '0;
						ofcol_q  <= '0;
						ofrow_q  <= '0;
						oecol_q  <= '0;
						oerow_q  <= '0;
						olast_q  <= 1'b1;
						otrunc_q <= 1'b0;
						oleft_q  <= tot_sat;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign stamp.valid           = ovalid_q;
	assign stamp.stamp_valid     = ostamp_q;
	assign stamp.draw_x          = odx_q;
	assign stamp.draw_y          = ody_q;
	assign stamp.brush_first_col = ofcol_q;
	assign stamp.brush_first_row = ofrow_q;
	assign stamp.brush_end_col   = oecol_q;
	assign stamp.brush_end_row   = oerow_q;
	assign stamp.leftover_out    = oleft_q;
	assign stamp.truncated       = otrunc_q;
	assign stamp.last            = olast_q;

endmodule

// ===== rtl/core/bssp_clip.sv =====
module bssp_clip (
	input  logic signed [bssp_pkg::DRAW_W-1:0] draw,
	input  logic [bssp_pkg::SIZE_W-1:0]        size,
	input  logic [bssp_pkg::CANV_W-1:0]        canvas,
	output logic signed [bssp_pkg::OUT_W-1:0]  origin,
	output logic [bssp_pkg::OUT_W-2:0]         first,
	output logic signed [bssp_pkg::OUT_W-1:0]  bound
);
	import bssp_pkg::*;

	logic signed [DRAW_W-1:0] org;
	logic signed [DRAW_W-1:0] neg;
	logic signed [DRAW_W-1:0] room;
	logic signed [DRAW_W-1:0] sz;
	logic signed [DRAW_W-1:0] cv;

	always_comb begin
		sz   = $signed({{(DRAW_W-SIZE_W){1'b0}}, size});
		cv   = $signed({{(DRAW_W-CANV_W){1'b0}}, canvas});
		neg  = -draw;
		org  = draw[DRAW_W-1] ? '0 : draw;
		room = cv - (org + sz);
		origin = org[OUT_W-1:0];
		first  = draw[DRAW_W-1] ? neg[OUT_W-2:0] : '0;
		bound  = room[DRAW_W-1] ? OUT_W'(cv - org) : OUT_W'(sz);
	end

endmodule
